/* rtl/hrsp_pkg.sv */
// ----------------------------------------------------------------------------
// hrsp_pkg
// Shared types, constants and helper functions of the request stream parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

  localparam int unsigned PathBytesDef  = 256;
  localparam int unsigned QueryBytesDef = 256;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned MaxResults    = 4;

  localparam logic [2:0] KIND_PATH  = 3'd0;
  localparam logic [2:0] KIND_QUERY = 3'd1;
  localparam logic [2:0] KIND_DONE  = 3'd2;
  localparam logic [2:0] KIND_BODY  = 3'd3;
  localparam logic [2:0] KIND_BAD   = 3'd4;

  localparam logic [2:0] METH_GET    = 3'd0;
  localparam logic [2:0] METH_POST   = 3'd1;
  localparam logic [2:0] METH_PUT    = 3'd2;
  localparam logic [2:0] METH_DELETE = 3'd3;
  localparam logic [2:0] METH_OTHER  = 3'd4;

  localparam logic [30:0] LenMax = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       connection_start;
  } hrsp_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [2:0]  method;
    logic [30:0] body_len;
    logic        conn_alive;
    logic        last;
  } hrsp_out_t;

  // One accepted byte's worth of results, up to four.
  typedef struct packed {
    logic [2:0]            count;
    hrsp_out_t [MaxResults-1:0] res;
  } hrsp_group_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c <= 8'h39) t = c - 8'h30;
    else if (c >= 8'h61) t = c - 8'h57;
    else t = c - 8'h37;
    return t[3:0];
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] cl_char(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = "c";  4'd1: r = "o";  4'd2: r = "n";  4'd3: r = "t";
      4'd4: r = "e";  4'd5: r = "n";  4'd6: r = "t";  4'd7: r = "-";
      4'd8: r = "l";  4'd9: r = "e";  4'd10: r = "n"; 4'd11: r = "g";
      4'd12: r = "t"; 4'd13: r = "h"; 4'd14: r = ":";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cn_char(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = "c"; 4'd1: r = "o"; 4'd2: r = "n"; 4'd3: r = "n";
      4'd4: r = "e"; 4'd5: r = "c"; 4'd6: r = "t"; 4'd7: r = "i";
      4'd8: r = "o"; 4'd9: r = "n"; 4'd10: r = ":";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic hrsp_out_t mk_res(input logic [2:0] k, input logic [7:0] b);
    hrsp_out_t r;
    r = '0;
    r.kind = k;
    r.out_byte = b;
    return r;
  endfunction

endpackage

/* rtl/hrsp_front.sv */
// ----------------------------------------------------------------------------
// hrsp_front
// Byte classifier and parser state: turns one byte into a result group.
// ----------------------------------------------------------------------------
module hrsp_front import hrsp_pkg::*; #(
  parameter int unsigned PathBytes  = PathBytesDef,
  parameter int unsigned QueryBytes = QueryBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  hrsp_in_t    in_data_i,
  output logic        in_stall_o,
  output logic        grp_valid_o,
  output hrsp_group_t grp_o,
  input  logic        grp_full_i
);

  localparam int unsigned PW = $clog2(PathBytes);
  localparam int unsigned QW = $clog2(QueryBytes);
  localparam logic [PW-1:0] PathLim  = PW'(PathBytes - 1);
  localparam logic [QW-1:0] QueryLim = QW'(QueryBytes - 1);

  localparam logic [2:0] PH_METHOD  = 3'd0;
  localparam logic [2:0] PH_PATH    = 3'd1;
  localparam logic [2:0] PH_QUERY   = 3'd2;
  localparam logic [2:0] PH_VERSION = 3'd3;
  localparam logic [2:0] PH_HEADER  = 3'd4;
  localparam logic [2:0] PH_BODY    = 3'd5;
  localparam logic [2:0] PH_DEAD    = 3'd6;

  localparam int unsigned HM_CLP = 0;
  localparam int unsigned HM_CNP = 1;
  localparam int unsigned HM_CLV = 2;
  localparam int unsigned HM_CNV = 3;

  logic [2:0]  phase_q, phase_d;
  logic [47:0] mchars_q, mchars_d;
  logic [2:0]  mlen_q, mlen_d;
  logic [1:0]  pheld_q, pheld_d;
  logic [7:0]  hexc_q, hexc_d;
  logic        crp_q, crp_d;
  logic [PW-1:0] pcnt_q, pcnt_d;
  logic [QW-1:0] qcnt_q, qcnt_d;
  logic [15:0] llen_q, llen_d;
  logic [3:0]  hm_q, hm_d;
  logic [79:0] win_q, win_d;
  logic [30:0] acc_q, acc_d;
  logic [1:0]  sgn_q, sgn_d;
  logic [30:0] lreg_q, lreg_d;
  logic        alive_q, alive_d;
  logic [30:0] brem_q, brem_d;

  logic        take;
  hrsp_group_t g;

  assign in_stall_o  = grp_full_i;
  assign take        = in_valid_i && !grp_full_i;
  assign grp_valid_o = take && (g.count != 3'd0);
  assign grp_o       = g;

  always_comb begin
    logic [7:0]  b, lb, c;
    logic [2:0]  n;
    logic        is_lf, do_line, do_byte, dig;
    logic [34:0] mul;
    logic [35:0] sum;
    logic [2:0]  mcode;
    logic [3:0]  pos;

    phase_d = phase_q; mchars_d = mchars_q; mlen_d = mlen_q;
    pheld_d = pheld_q; hexc_d = hexc_q; crp_d = crp_q;
    pcnt_d = pcnt_q; qcnt_d = qcnt_q; llen_d = llen_q; hm_d = hm_q;
    win_d = win_q; acc_d = acc_q; sgn_d = sgn_q; lreg_d = lreg_q;
    alive_d = alive_q; brem_d = brem_q;
    g = '0;
    n = 3'd0;
    b = in_data_i.data_byte;
    lb = 8'h00; c = 8'h00; dig = 1'b0; mul = '0; sum = '0; mcode = METH_OTHER;
    pos = 4'd0; do_line = 1'b0; do_byte = 1'b0; is_lf = 1'b0;

    if (in_data_i.connection_start) begin
      phase_d = PH_METHOD; mchars_d = '0; mlen_d = '0; pheld_d = '0; hexc_d = '0;
      crp_d = 1'b0; pcnt_d = '0; qcnt_d = '0; llen_d = '0; hm_d = '0; win_d = '0;
      acc_d = '0; sgn_d = '0; lreg_d = '0; alive_d = 1'b0; brem_d = '0;
    end

    if (phase_d == PH_BODY) begin
      brem_d = brem_d - 31'd1;
      g.res[0] = mk_res(KIND_BODY, b);
      g.res[0].last = (brem_d == '0);
      n = 3'd1;
      if (brem_d == '0) begin
        phase_d = PH_METHOD; mchars_d = '0; mlen_d = '0; pheld_d = '0; hexc_d = '0;
        crp_d = 1'b0; pcnt_d = '0; qcnt_d = '0; llen_d = '0; hm_d = '0; win_d = '0;
        acc_d = '0; sgn_d = '0; lreg_d = '0; alive_d = 1'b0; brem_d = '0;
      end
    end else if (phase_d != PH_DEAD && phase_d != 3'd7) begin
      // pass 0: a held CR, pass 1: the current byte
      for (int p = 0; p < 2; p++) begin
        do_line = 1'b0; do_byte = 1'b0; c = b;
        if (p == 0) begin
          if (crp_d) begin
            crp_d = 1'b0;
            if (b == 8'h0A) begin
              do_line = 1'b1; is_lf = 1'b1;
            end else begin
              do_byte = 1'b1; c = 8'h0D;
            end
          end
        end else if (!is_lf) begin
          if (b == 8'h0D) crp_d = 1'b1;
          else if (b == 8'h0A) do_line = 1'b1;
          else do_byte = 1'b1;
        end
        if (do_byte) begin
          case (phase_d)
            PH_METHOD: begin
              if (c == 8'h20) phase_d = PH_PATH;
              else if (mlen_d < 3'd6) begin
                mchars_d = mchars_d | (48'(c) << (8 * mlen_d));
                mlen_d = mlen_d + 3'd1;
              end else mlen_d = 3'd7;
            end
            PH_PATH: begin
              if (c == 8'h3F || c == 8'h20 ||
                  (pheld_d == 2'd1 && !is_hex(c)) || (pheld_d == 2'd2 && !is_hex(c))) begin
                if (pheld_d >= 2'd1 && pcnt_d < PathLim) begin
                  pcnt_d = pcnt_d + 1'b1; g.res[n[1:0]] = mk_res(KIND_PATH, 8'h25);
                  n = n + 3'd1;
                end
                if (pheld_d == 2'd2 && pcnt_d < PathLim) begin
                  pcnt_d = pcnt_d + 1'b1; g.res[n[1:0]] = mk_res(KIND_PATH, hexc_d);
                  n = n + 3'd1;
                end
                pheld_d = 2'd0;
                if (c == 8'h3F) phase_d = PH_QUERY;
                else if (c == 8'h20) phase_d = PH_VERSION;
                else if (c == 8'h25) pheld_d = 2'd1;
                else if (pcnt_d < PathLim) begin
                  pcnt_d = pcnt_d + 1'b1; g.res[n[1:0]] = mk_res(KIND_PATH, c);
                  n = n + 3'd1;
                end
              end else if (pheld_d == 2'd1) begin
                hexc_d = c; pheld_d = 2'd2;
              end else if (pheld_d == 2'd2) begin
                pheld_d = 2'd0;
                if (pcnt_d < PathLim) begin
                  pcnt_d = pcnt_d + 1'b1;
                  g.res[n[1:0]] = mk_res(KIND_PATH, {hex_val(hexc_d), hex_val(c)});
                  n = n + 3'd1;
                end
              end else if (c == 8'h25) pheld_d = 2'd1;
              else if (pcnt_d < PathLim) begin
                pcnt_d = pcnt_d + 1'b1; g.res[n[1:0]] = mk_res(KIND_PATH, c);
                n = n + 3'd1;
              end
            end
            PH_QUERY: begin
              if (c == 8'h20) phase_d = PH_VERSION;
              else if (qcnt_d < QueryLim) begin
                qcnt_d = qcnt_d + 1'b1; g.res[n[1:0]] = mk_res(KIND_QUERY, c);
                n = n + 3'd1;
              end
            end
            PH_HEADER: begin
              lb = to_lower(c);
              pos = llen_d[3:0];
              dig = (c >= 8'h30 && c <= 8'h39);
              if (hm_d[HM_CLP] || hm_d[HM_CNP]) begin
                if (hm_d[HM_CLP] && llen_d < 16'd15) begin
                  if (lb != cl_char(pos)) hm_d[HM_CLP] = 1'b0;
                  else if (llen_d == 16'd14) begin
                    hm_d = 4'b0100; acc_d = '0; sgn_d = '0;
                  end
                end
                if (hm_d[HM_CNP] && llen_d < 16'd11) begin
                  if (lb != cn_char(pos)) hm_d[HM_CNP] = 1'b0;
                  else if (llen_d == 16'd10) begin
                    hm_d = 4'b1000; win_d = '0;
                  end
                end
              end else if (hm_d[HM_CLV]) begin
                mul = 35'(acc_d) * 35'd10;
                sum = 36'(mul) + 36'(c - 8'h30);
                if (sgn_d == 2'd0) begin
                  if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h0C) begin
                  end else if (c == 8'h2B) sgn_d = 2'd1;
                  else if (!dig) begin acc_d = '0; sgn_d = 2'd3; end
                  else begin
                    sgn_d = 2'd2; acc_d = (sum > 36'(LenMax)) ? LenMax : sum[30:0];
                  end
                end else if (sgn_d != 2'd3) begin
                  if (!dig) sgn_d = 2'd3;
                  else begin
                    sgn_d = 2'd2; acc_d = (sum > 36'(LenMax)) ? LenMax : sum[30:0];
                  end
                end
              end else if (hm_d[HM_CNV]) begin
                win_d = {c, win_d[79:8]};
                if (win_d == {"evila-peek"}) alive_d = 1'b1;
              end
              if (llen_d != 16'hFFFF) llen_d = llen_d + 16'd1;
            end
            default: begin
            end
          endcase
        end
        if (do_line) begin
          case (phase_d)
            PH_METHOD: begin
              g.res[n[1:0]] = mk_res(KIND_BAD, 8'h00);
              g.res[n[1:0]].last = 1'b1;
              n = n + 3'd1;
              phase_d = PH_DEAD;
            end
            PH_PATH, PH_QUERY, PH_VERSION: begin
              if (phase_d == PH_PATH) begin
                if (pheld_d >= 2'd1 && pcnt_d < PathLim) begin
                  pcnt_d = pcnt_d + 1'b1; g.res[n[1:0]] = mk_res(KIND_PATH, 8'h25);
                  n = n + 3'd1;
                end
                if (pheld_d == 2'd2 && pcnt_d < PathLim) begin
                  pcnt_d = pcnt_d + 1'b1; g.res[n[1:0]] = mk_res(KIND_PATH, hexc_d);
                  n = n + 3'd1;
                end
                pheld_d = 2'd0;
              end
              phase_d = PH_HEADER; llen_d = '0; hm_d = 4'b0011;
            end
            PH_HEADER: begin
              if (llen_d == '0) begin
                if (mlen_d == 3'd3 && mchars_d == 48'h544547) mcode = METH_GET;
                else if (mlen_d == 3'd4 && mchars_d == 48'h54534F50) mcode = METH_POST;
                else if (mlen_d == 3'd3 && mchars_d == 48'h545550) mcode = METH_PUT;
                else if (mlen_d == 3'd6 && mchars_d == 48'h4554454C4544) mcode = METH_DELETE;
                else mcode = METH_OTHER;
                g.res[n[1:0]] = mk_res(KIND_DONE, 8'h00);
                g.res[n[1:0]].method = mcode;
                g.res[n[1:0]].body_len = lreg_d;
                g.res[n[1:0]].conn_alive = alive_d;
                g.res[n[1:0]].last = (lreg_d == '0);
                n = n + 3'd1;
                if (lreg_d == '0) begin
                  phase_d = PH_METHOD; mchars_d = '0; mlen_d = '0; pheld_d = '0;
                  hexc_d = '0; crp_d = 1'b0; pcnt_d = '0; qcnt_d = '0; llen_d = '0;
                  hm_d = '0; win_d = '0; acc_d = '0; sgn_d = '0; alive_d = 1'b0;
                  brem_d = '0;
                end else begin
                  phase_d = PH_BODY; brem_d = lreg_d;
                end
              end else begin
                if (hm_d[HM_CLV]) lreg_d = acc_d;
                phase_d = PH_HEADER; llen_d = '0; hm_d = 4'b0011;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
    g.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_METHOD; mchars_q <= '0; mlen_q <= '0; pheld_q <= '0;
      hexc_q <= '0; crp_q <= 1'b0; pcnt_q <= '0; qcnt_q <= '0; llen_q <= '0;
      hm_q <= '0; win_q <= '0; acc_q <= '0; sgn_q <= '0; lreg_q <= '0;
      alive_q <= 1'b0; brem_q <= '0;
    end else if (take) begin
      phase_q <= phase_d; mchars_q <= mchars_d; mlen_q <= mlen_d; pheld_q <= pheld_d;
      hexc_q <= hexc_d; crp_q <= crp_d; pcnt_q <= pcnt_d; qcnt_q <= qcnt_d;
      llen_q <= llen_d; hm_q <= hm_d; win_q <= win_d; acc_q <= acc_d; sgn_q <= sgn_d;
      lreg_q <= lreg_d; alive_q <= alive_d; brem_q <= brem_d;
    end
  end

endmodule

/* rtl/hrsp_queue.sv */
// ----------------------------------------------------------------------------
// hrsp_queue
// Small FIFO of result groups between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module hrsp_queue import hrsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  hrsp_group_t push_data_i,
  output logic        full_o,
  output logic        empty_o,
  output hrsp_group_t head_o,
  input  logic        pop_i
);

  localparam int unsigned AW = $clog2(QueueDepth);

  hrsp_group_t   mem_q [QueueDepth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

endmodule

/* rtl/hrsp_back.sv */
// ----------------------------------------------------------------------------
// hrsp_back
// Output sequencer: emits the results of each group one per transfer.
// ----------------------------------------------------------------------------
module hrsp_back import hrsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  hrsp_group_t q_head_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  output hrsp_out_t   out_data_o,
  input  logic        out_stall_i
);

  logic [1:0] idx_q;
  logic       fire, end_grp;

  assign out_valid_o = !q_empty_i;
  assign out_data_o  = q_head_i.res[idx_q];
  assign fire        = out_valid_o && !out_stall_i;
  assign end_grp     = (3'(idx_q) + 3'd1 == q_head_i.count);
  assign q_pop_o     = fire && end_grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else if (fire) idx_q <= end_grp ? 2'd0 : idx_q + 2'd1;
  end

endmodule

/* rtl/http_request_stream_parser_core.sv */
// ----------------------------------------------------------------------------
// http_request_stream_parser_core
// HTTP/1.1 request header parser with streamed path, query and body output.
// ----------------------------------------------------------------------------
// One request byte is taken per cycle while the result queue has room. Each
// byte yields zero to four results, queued as one group and sent out one per
// cycle while out_stall_i is low, so the sustained rate is one byte per cycle
// when each byte gives at most one result; bytes that produce several results
// (such as escape flushes) go out one result per transfer on the single output port.
module http_request_stream_parser_core import hrsp_pkg::*; #(
  parameter int unsigned PathBytes  = PathBytesDef,
  parameter int unsigned QueryBytes = QueryBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  hrsp_in_t  in_data_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output hrsp_out_t out_data_o,
  input  logic      out_stall_i
);

  logic        push, full, empty, pop;
  hrsp_group_t grp, head;

  hrsp_front #(.PathBytes(PathBytes), .QueryBytes(QueryBytes)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_data_i, .in_stall_o,
    .grp_valid_o(push), .grp_o(grp), .grp_full_i(full)
  );

  hrsp_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(grp), .full_o(full),
    .empty_o(empty), .head_o(head), .pop_i(pop)
  );

  hrsp_back u_back (
    .clk_i, .rst_ni, .q_empty_i(empty), .q_head_i(head), .q_pop_o(pop),
    .out_valid_o, .out_data_o, .out_stall_i
  );

endmodule

/* rtl/hrsp_checker.sv */
// ----------------------------------------------------------------------------
// hrsp_checker
// Port-level checks of the parser core.
// ----------------------------------------------------------------------------
module hrsp_checker import hrsp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input hrsp_out_t out_data_o,
  input logic      out_stall_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.kind <= KIND_BAD)
    else $error("bad kind");

  a_bad_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_BAD |-> out_data_o.last)
    else $error("malformed without last");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |->
      (out_data_o.kind == KIND_BAD || out_data_o.kind == KIND_BODY ||
       (out_data_o.kind == KIND_DONE && out_data_o.body_len == '0)))
    else $error("last on wrong result");

endmodule

bind http_request_stream_parser_core hrsp_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_data_o, .out_stall_i
);

/* tb/http_request_stream_parser_core_tb.sv */
// ----------------------------------------------------------------------------
// http_request_stream_parser_core_tb
// Self-checking bench for the request stream parser. A short table of
// handwritten requests runs first, then randomly built requests with noise.
// Each result is checked against an in-bench model or a fixed table entry, with
// random idle cycles on both sides, one long receiver hold and a sender drain.
// ----------------------------------------------------------------------------
module http_request_stream_parser_core_tb;
  import hrsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ST_METHOD, ST_PATH, ST_QUERY, ST_VERSION, ST_HEADER, ST_BODY, ST_DEAD
  } parse_st_e;

  typedef struct {
    logic [7:0] b;
    logic       cs;
    bit         fixed;
    hrsp_out_t  res;
  } stim_t;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 20;
  localparam string ClText = "content-length:";
  localparam string CnText = "connection:";

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  hrsp_in_t  in_data_i = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  hrsp_out_t out_data_o;
  logic      out_stall_i = 1'b0;

  http_request_stream_parser_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_data_i, .in_stall_o,
    .out_valid_o, .out_data_o, .out_stall_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- parser model ----------------
  parse_st_e   st;
  logic [47:0] mchars;
  int          mlen, pct, sgn;
  logic [7:0]  held;
  bit          crp, alive;
  int          pcnt, qcnt;
  int unsigned llen;
  logic [3:0]  hm;
  logic [79:0] win;
  logic [30:0] num, lenreg, remain;
  hrsp_out_t   step_res[$];
  hrsp_out_t   exp_res[$];

  function automatic void new_request();
    st = ST_METHOD; mchars = '0; mlen = 0; pct = 0; held = '0; crp = 0;
    pcnt = 0; qcnt = 0; llen = 0; hm = '0; win = '0; num = '0; sgn = 0;
    lenreg = '0; alive = 0; remain = '0;
  endfunction

  function automatic hrsp_out_t fx(logic [2:0] k, logic [2:0] m, logic [30:0] l,
                                   logic a, logic lst);
    hrsp_out_t r;
    r = '0;
    r.kind = k; r.method = m; r.body_len = l; r.conn_alive = a; r.last = lst;
    return r;
  endfunction

  function automatic void put(logic [2:0] k, logic [7:0] b, logic [2:0] m,
                              logic [30:0] l, logic a, logic lst);
    hrsp_out_t r;
    r = fx(k, m, l, a, lst);
    r.out_byte = b;
    if (step_res.size() < MaxResults) step_res.push_back(r);
  endfunction

  function automatic int hexv(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  function automatic void emit_path(logic [7:0] b);
    if (pcnt < PathBytesDef - 1) begin
      pcnt++;
      put(KIND_PATH, b, '0, '0, 0, 0);
    end
  endfunction

  function automatic void flush_pct();
    if (pct >= 1) emit_path("%");
    if (pct == 2) emit_path(held);
    pct = 0;
  endfunction

  function automatic void decode(logic [7:0] b);
    logic [7:0] v;
    if (pct == 1) begin
      if (hexv(b) >= 0) begin
        held = b; pct = 2;
        return;
      end
      flush_pct();
    end else if (pct == 2) begin
      if (hexv(b) >= 0) begin
        v = 8'(hexv(held) * 16 + hexv(b));
        pct = 0;
        emit_path(v);
        return;
      end
      flush_pct();
    end
    if (b == "%") pct = 1;
    else emit_path(b);
  endfunction

  function automatic void number_byte(logic [7:0] b);
    bit digit;
    longint unsigned v;
    digit = (b >= "0" && b <= "9");
    if (sgn == 0) begin
      if (b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0B || b == 8'h0C) return;
      if (b == "+") begin sgn = 1; return; end
      if (!digit) begin num = '0; sgn = 3; return; end
      sgn = 2;
    end else if (sgn == 1) begin
      if (!digit) begin sgn = 3; return; end
      sgn = 2;
    end else if (sgn == 2) begin
      if (!digit) begin sgn = 3; return; end
    end else begin
      return;
    end
    v = longint'(num) * 10 + (b - 8'h30);
    num = (v > LenMax) ? LenMax : v[30:0];
  endfunction

  function automatic void header_byte(logic [7:0] b);
    int unsigned pos;
    logic [7:0] lb;
    pos = llen;
    lb = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    if (hm[1:0] != 0) begin
      if (hm[0] && pos < 15) begin
        if (lb != ClText[pos]) hm[0] = 0;
        else if (pos == 14) begin
          hm = 4'd4; num = '0; sgn = 0;
        end
      end
      if (hm[1] && pos < 11) begin
        if (lb != CnText[pos]) hm[1] = 0;
        else if (pos == 10) begin
          hm = 4'd8; win = '0;
        end
      end
    end else if (hm[2]) begin
      number_byte(b);
    end else if (hm[3]) begin
      win = {win[71:0], b};
      if (win == "keep-alive") alive = 1;
    end
    if (llen < 16'hFFFF) llen++;
  endfunction

  function automatic void start_header();
    st = ST_HEADER; llen = 0; hm = 4'd3;
  endfunction

  function automatic void line_byte(logic [7:0] b);
    case (st)
      ST_METHOD: begin
        if (b == " ") st = ST_PATH;
        else if (mlen < 6) begin
          mchars = {mchars[39:0], b}; mlen++;
        end else mlen = 7;
      end
      ST_PATH: begin
        if (b == "?") begin flush_pct(); st = ST_QUERY; end
        else if (b == " ") begin flush_pct(); st = ST_VERSION; end
        else decode(b);
      end
      ST_QUERY: begin
        if (b == " ") st = ST_VERSION;
        else if (qcnt < QueryBytesDef - 1) begin
          qcnt++;
          put(KIND_QUERY, b, '0, '0, 0, 0);
        end
      end
      ST_HEADER: header_byte(b);
      default: ;
    endcase
  endfunction

  function automatic logic [2:0] method_of();
    if (mlen == 3 && mchars == {24'd0, "GET"}) return METH_GET;
    if (mlen == 4 && mchars == {16'd0, "POST"}) return METH_POST;
    if (mlen == 3 && mchars == {24'd0, "PUT"}) return METH_PUT;
    if (mlen == 6 && mchars == "DELETE") return METH_DELETE;
    return METH_OTHER;
  endfunction

  function automatic void close_line();
    logic [30:0] l;
    case (st)
      ST_METHOD: begin
        put(KIND_BAD, '0, '0, '0, 0, 1);
        st = ST_DEAD;
      end
      ST_PATH: begin flush_pct(); start_header(); end
      ST_QUERY, ST_VERSION: start_header();
      ST_HEADER: begin
        if (llen == 0) begin
          l = lenreg;
          put(KIND_DONE, '0, method_of(), l, alive, l == 0);
          if (l == 0) new_request();
          else begin st = ST_BODY; remain = l; end
          return;
        end
        if (hm[2]) lenreg = num;
        start_header();
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic cs);
    step_res.delete();
    if (cs) new_request();
    if (st == ST_BODY) begin
      remain--;
      put(KIND_BODY, b, '0, '0, 0, remain == 0);
      if (remain == 0) new_request();
      return;
    end
    if (st == ST_DEAD) return;
    if (crp) begin
      crp = 0;
      if (b == 8'h0A) begin close_line(); return; end
      line_byte(8'h0D);
    end
    if (b == 8'h0D) crp = 1;
    else if (b == 8'h0A) close_line();
    else line_byte(b);
  endfunction

  // ---------------- stimulus table ----------------
  stim_t stim[$];
  bit    need_cs;

  task automatic add_byte(logic [7:0] b, logic cs);
    stim.push_back('{b, cs, 0, '0});
  endtask

  task automatic add_text(string s, bit cs0);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], cs0 && i == 0);
  endtask

  task automatic add_eol();
    if ($urandom_range(0, 1)) add_text("\r\n", 0);
    else add_text("\n", 0);
  endtask

  task automatic add_fixed(logic [7:0] b, hrsp_out_t r);
    stim.push_back('{b, 1'b0, 1, r});
  endtask

  function automatic logic [7:0] rnd_path_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom_range(97, 122));
      3: return 8'($urandom_range(48, 57));
      4: return "+";
      5: return "%";
      6: return 8'($urandom_range(65, 70));
      7: return 8'($urandom_range(128, 255));
      8: return 8'h0D;
      default: return 8'($urandom_range(33, 62));
    endcase
  endfunction

  task automatic gen_request();
    int n, cl;
    string s;
    bit big;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(3, 12);
      repeat (n) add_byte(8'($urandom()), $urandom_range(0, 3) == 0);
      need_cs = 1;
      return;
    end
    case ($urandom_range(0, 7))
      0: s = "GET"; 1: s = "POST"; 2: s = "PUT"; 3: s = "DELETE";
      4: s = "PATCHED"; 5: s = "GE"; 6: s = "get";
      default: s = "DELETEX";
    endcase
    add_text(s, need_cs || $urandom_range(0, 7) == 0);
    need_cs = 0;
    if ($urandom_range(0, 15) == 0) begin
      add_text("\r\n", 0);
      need_cs = 1;
      return;
    end
    add_text(" /", 0);
    n = ($urandom_range(0, 40) == 0) ? 300 : $urandom_range(0, 8);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        add_byte("%", 0);
        add_byte(8'($urandom_range(48, 57)), 0);
        add_byte(8'($urandom_range(65, 70)), 0);
      end else add_byte(rnd_path_char(), 0);
    end
    if ($urandom_range(0, 1)) begin
      add_byte("?", 0);
      n = ($urandom_range(0, 40) == 0) ? 300 : $urandom_range(0, 6);
      repeat (n) begin
        add_byte(8'($urandom_range(0, 255)), 0);
        if (stim[$].b == " " || stim[$].b == 8'h0A) stim[$].b = "=";
      end
    end
    if ($urandom_range(0, 3) != 0) add_text(" HTTP/1.1", 0);
    add_eol();
    cl = 0;
    big = 0;
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          add_text($urandom_range(0, 1) ? "Content-Length:" : "CONTENT-length:", 0);
          if ($urandom_range(0, 1)) add_text(" \t", 0);
          case ($urandom_range(0, 7))
            0: begin add_text("-4", 0); cl = 0; big = 0; end
            1: begin add_text("x1", 0); cl = 0; big = 0; end
            2: begin add_text("99999999999", 0); big = 1; end
            default: begin
              if ($urandom_range(0, 2) == 0) add_byte("+", 0);
              cl = $urandom_range(0, 6);
              add_byte(8'(48 + cl), 0);
              big = 0;
              if ($urandom_range(0, 2) == 0) add_text(" 7", 0);
            end
          endcase
        end
        2: begin
          if ($urandom_range(0, 1)) add_text("Connection: keep-alive", 0);
          else add_text("connection: close, keep-alivE", 0);
        end
        3: add_text("Content-Lengthy: 5", 0);
        default: begin
          add_text("Host: ", 0);
          repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(32, 126)), 0);
        end
      endcase
      add_eol();
    end
    add_eol();
    repeat (big ? 5 : cl) add_byte(8'($urandom()), 0);
    if (big) need_cs = 1;
  endtask

  task automatic build_stim();
    add_text("X", 1);
    add_fixed(8'h0A, fx(KIND_BAD, '0, '0, 0, 1));
    add_text("zz", 0);
    add_text("GET /a%41%4g%+b?q=", 1);
    add_byte(8'hFF, 0);
    add_byte(8'h00, 0);
    add_text(" HTTP\r\nconnection: a keep-alive\r\nContent-length:\t+3\r\n\r\nabc", 0);
    add_text("DELETE /%4\nCONTENT-LENGTH: -5\n", 0);
    add_fixed(8'h0A, fx(KIND_DONE, METH_DELETE, '0, 0, 1));
    add_text("PUTTERED /x\rz\r\r\nContent-Length: 99999999999\n\nqq", 0);
    add_text("POST /p?\n", 1);
    add_fixed(8'h0A, fx(KIND_DONE, METH_POST, '0, 0, 1));
    need_cs = 0;
    while (stim.size() < 480) gen_request();
  endtask

  // ---------------- driving and checking ----------------
  int  errors = 0;
  int  idle_cycles = 0;
  int  rx_wait = 0;
  int  hold_cnt = 0;
  bit  hold_go = 0;
  int  n_out = 0;
  int  n_in = 0;

  initial begin
    int gap;
    build_stim();
    new_request();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    for (int i = 0; i < stim.size(); i++) begin
      if (i == 250) hold_go = 1;
      if (i == 400) begin
        while (exp_res.size() != 0) @(negedge clk_i) in_valid_i = 1'b0;
        repeat (DrainCycles) @(negedge clk_i) in_valid_i = 1'b0;
      end
      gap = ((i / 64) % 3 == 0) ? 0 : $urandom_range(0, 3);
      repeat (gap) @(negedge clk_i) in_valid_i = 1'b0;
      @(negedge clk_i);
      in_valid_i = 1'b1;
      in_data_i = '{data_byte: stim[i].b, connection_start: stim[i].cs};
      do @(posedge clk_i); while (in_stall_o);
      parse_byte(stim[i].b, stim[i].cs);
      if (stim[i].fixed) exp_res.push_back(stim[i].res);
      else foreach (step_res[k]) exp_res.push_back(step_res[k]);
      n_in++;
    end
    @(negedge clk_i) in_valid_i = 1'b0;
    while (exp_res.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (exp_res.size() != 0) begin
      $error("%0d expected results never arrived", exp_res.size());
      errors++;
    end
    $display("Fed %0d request bytes (directed and random requests, noise, long paths),",
             n_in);
    $display("and checked %0d result transfers with %0d mismatches.", n_out, errors);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_go = 0;
      hold_cnt = HoldCycles;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i = 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall_i = 1'b1;
    end else out_stall_i = 1'b0;
  end

  always @(posedge clk_i) begin
    hrsp_out_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        idle_cycles = 0;
        n_out++;
        rx_wait = ((n_out / 80) % 3 == 0) ? 0 : $urandom_range(0, 3);
        if (exp_res.size() == 0) begin
          $error("result transfer with no expectation: kind %0d", out_data_o.kind);
          errors++;
        end else begin
          e = exp_res.pop_front();
          if (out_data_o.kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, out_data_o.kind); errors++;
          end
          if (out_data_o.out_byte !== e.out_byte) begin
            $error("out_byte: expected %0h, got %0h", e.out_byte, out_data_o.out_byte);
            errors++;
          end
          if (out_data_o.method !== e.method) begin
            $error("method: expected %0d, got %0d", e.method, out_data_o.method); errors++;
          end
          if (out_data_o.body_len !== e.body_len) begin
            $error("body_len: expected %0d, got %0d", e.body_len,
                   out_data_o.body_len);
            errors++;
          end
          if (out_data_o.conn_alive !== e.conn_alive) begin
            $error("conn_alive: expected %0b, got %0b", e.conn_alive, out_data_o.conn_alive);
            errors++;
          end
          if (out_data_o.last !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, out_data_o.last); errors++;
          end
        end
      end else if (in_valid_i && !in_stall_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

endmodule

/* filelist.f */
rtl/hrsp_pkg.sv
rtl/hrsp_front.sv
rtl/hrsp_queue.sv
rtl/hrsp_back.sv
rtl/http_request_stream_parser_core.sv
rtl/hrsp_checker.sv
tb/http_request_stream_parser_core_tb.sv
